// ===== src/tbca_pkg.sv =====
// ----------------------------------------------------------------------------
// tbca_pkg
// Shared types, widths and codes of the tail buffer chunk allocator.
// ----------------------------------------------------------------------------
package tbca_pkg;

  // Size of the header store in bytes and payload alignment (power of two)
  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned ALIGN_BYTES = 8;

  // One header word per 4-byte slot
  localparam int unsigned DEPTH = STORE_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  // Byte offsets from 0 up to and including STORE_BYTES
  localparam int unsigned OFF_W = IDX_W + 3;
  // Chunk sizes and sums of an offset and a size
  localparam int unsigned SIZ_W = OFF_W + 1;
  localparam int unsigned HDR_W = SIZ_W;

  // Fixed field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned NBYTES_W  = 32;
  localparam int unsigned BUF_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = CFG_IDX_W'(1);

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0] BASE_RESET = '0;
  localparam logic [BUF_W-1:0]  BUF_RESET  = BUF_W'(4096);

  // Used flag in bit 0 of a header word
  localparam logic [HDR_W-1:0] USED_FLAG = HDR_W'(1);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_SYSTEM    = 2'd1,
    ST_MOVED     = 2'd2,
    ST_TO_SYSTEM = 2'd3
  } status_e;

  // Chunk size of a request: header plus aligned payload
  typedef struct packed {
    logic             too_big;  // cannot fit in any buffer
    logic [SIZ_W-1:0] bytes;    // valid when too_big is low
  } chunk_size_t;

  // Size field of a header word
  function automatic logic [HDR_W-1:0] hdr_size(logic [HDR_W-1:0] h);
    return h & ~USED_FLAG;
  endfunction

endpackage

// ===== src/tbca_req_if.sv =====
// ----------------------------------------------------------------------------
// tbca_req_if
// Request channel of the chunk allocator: command, address, size.
// ----------------------------------------------------------------------------
interface tbca_req_if;
  import tbca_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [ADDR_W-1:0]   address;
  logic [NBYTES_W-1:0] request_bytes;

  modport source (output valid, command, address, request_bytes, input ready);
  modport sink   (input valid, command, address, request_bytes, output ready);

endinterface

// ===== src/tbca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tbca_rsp_if
// Response channel of the chunk allocator: status and payload address.
// ----------------------------------------------------------------------------
interface tbca_rsp_if;
  import tbca_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] result_address;

  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);

endinterface

// ===== src/tbca_chunk_size.sv =====
// ----------------------------------------------------------------------------
// tbca_chunk_size
// Turns a payload byte count into the chunk size it takes in the buffer.
// ----------------------------------------------------------------------------
module tbca_chunk_size (
  input  logic [tbca_pkg::NBYTES_W-1:0] nbytes_i,
  output tbca_pkg::chunk_size_t         size_o
);
  import tbca_pkg::*;

  localparam logic [SIZ_W-1:0] ALIGN_MASK = SIZ_W'(ALIGN_BYTES - 1);
  localparam logic [SIZ_W-1:0] WORD_MASK  = SIZ_W'(3);

  logic [SIZ_W-1:0] low;
  logic [SIZ_W-1:0] aligned;
  logic [SIZ_W-1:0] worded;

  // Counts at or above twice the store can never fit
  assign low = SIZ_W'(nbytes_i[OFF_W-1:0]);

  // Round up to the alignment, then to whole words, then add the header
  always_comb begin
    aligned = (low + ALIGN_MASK) & ~ALIGN_MASK;
    worded  = (aligned + WORD_MASK) & ~WORD_MASK;
    size_o.too_big = |nbytes_i[NBYTES_W-1:OFF_W];
    size_o.bytes   = worded + SIZ_W'(4);
  end

endmodule

// ===== src/tail_buffer_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// tail_buffer_chunk_allocator
// Chunk header manager of one fixed buffer filled upward from its base.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (allocate, free or reallocate) with valid and
//   ready; rsp_o returns exactly one response per request, in order. The
//   block works on one request at a time; a new request is taken while the
//   previous response still waits in the output register.
//   Allocate and addresses outside the buffer are answered from the decode
//   state; free and reallocate first walk the headers from the base up to
//   the addressed chunk, and a released chunk then passes the release
//   states (read successor, merge, merge predecessor). The walk reads one
//   header at a time, a read state then a check state per header, from the
//   single-port header memory and sets the throughput.
//   Configuration (base address, buffer size) is written on cfg_we_i; the user
//   writes it only while no request is in flight, the block does not enforce it.
//   Reset clears the tail offset and the configuration to its defaults; the
//   header memory is not cleared, only headers below the tail are read.
//   When rsp_o stalls, a finished response waits in the response stage and
//   the block holds until the output register is free.
// ----------------------------------------------------------------------------
module tail_buffer_chunk_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tbca_pkg::CFG_W-1:0]     cfg_wdata_i,
  tbca_req_if.sink                       req_i,
  tbca_rsp_if.source                     rsp_o
);
  import tbca_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_WALK_RD  = 9'b000000100,
    S_WALK_CHK = 9'b000001000,
    S_REALLOC  = 9'b000010000,
    S_REL_RD   = 9'b000100000,
    S_REL_CHK  = 9'b001000000,
    S_REL_PREV = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [ADDR_W-1:0] base_q;
  logic [BUF_W-1:0]  buf_bytes_q;
  logic [OFF_W-1:0]  eff_size;

  // Request context
  logic [1:0]        cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] off_q;
  chunk_size_t       csize, siz_q;

  // Allocator state and walk registers
  logic [OFF_W-1:0] tail_q, tail_d;
  logic [OFF_W-1:0] chunk_q, chunk_d;
  logic [SIZ_W-1:0] walk_q, walk_d;
  logic             has_prev_q, has_prev_d;
  logic [OFF_W-1:0] prev_q, prev_d;
  logic [HDR_W-1:0] prev_hdr_q, prev_hdr_d;
  logic [HDR_W-1:0] old_q, old_d;
  logic             next_live_q, next_live_d;
  logic [SIZ_W-1:0] merged_q, merged_d;

  // Pending response
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;

  // Header memory
  logic [HDR_W-1:0] hdr_mem [DEPTH];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [HDR_W-1:0] mem_wdata, mem_rdata_q;

  // Helpers
  logic             req_fire;
  logic [HDR_W-1:0] rsize;
  logic [SIZ_W-1:0] tail_w, eff_w, chunk_w, chunk_end, next_off;
  logic [SIZ_W-1:0] start_w, span;
  logic [OFF_W-1:0] start;
  logic             at_tail, fits_tail, fits_place;

  tbca_chunk_size u_chunk_size (
    .nbytes_i (req_i.request_bytes),
    .size_o   (csize)
  );

  // Size in effect is the smaller of the register and the store
  always_comb begin
    if (32'(buf_bytes_q) < 32'(STORE_BYTES)) begin
      eff_size = OFF_W'(buf_bytes_q);
    end else begin
      eff_size = OFF_W'(STORE_BYTES);
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RESET;
      buf_bytes_q <= BUF_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BASE_ADDRESS) begin
        base_q <= cfg_wdata_i[ADDR_W-1:0];
      end
      if (cfg_index_i == CFG_BUFFER_BYTES) begin
        buf_bytes_q <= cfg_wdata_i[BUF_W-1:0];
      end
    end
  end

  // Single-port header memory with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= hdr_mem[mem_raddr];
    end
  end

  // Latch the request context on acceptance
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q  <= req_i.command;
      addr_q <= req_i.address;
      off_q  <= req_i.address - base_q;
      siz_q  <= csize;
    end
  end

  // Shared arithmetic
  always_comb begin
    rsize      = hdr_size(mem_rdata_q);
    tail_w     = SIZ_W'(tail_q);
    eff_w      = SIZ_W'(eff_size);
    chunk_w    = SIZ_W'(chunk_q);
    chunk_end  = chunk_w + old_q;
    next_off   = chunk_end;
    at_tail    = (chunk_end == tail_w);
    fits_tail  = !siz_q.too_big && ((tail_w + siz_q.bytes) <= eff_w);
    fits_place = !siz_q.too_big &&
                 ((old_q >= siz_q.bytes) || (at_tail && (chunk_w + siz_q.bytes) <= eff_w));
    if (has_prev_q && !prev_hdr_q[0]) begin
      span  = merged_q + hdr_size(prev_hdr_q);
      start = prev_q;
    end else begin
      span  = merged_q;
      start = chunk_q;
    end
    start_w = SIZ_W'(start);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    tail_d       = tail_q;
    chunk_d      = chunk_q;
    walk_d       = walk_q;
    has_prev_d   = has_prev_q;
    prev_d       = prev_q;
    prev_hdr_d   = prev_hdr_q;
    old_d        = old_q;
    next_live_d  = next_live_q;
    merged_d     = merged_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_q[IDX_W+1:2];
    mem_wdata    = siz_q.bytes | USED_FLAG;
    mem_re       = 1'b0;
    mem_raddr    = walk_q[IDX_W+1:2];

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_d = ST_DONE;
        res_addr_d   = '0;
        state_d      = S_RESP;
        case (cmd_q) inside
          CMD_ALLOC: begin
            // Append at the tail when it fits
            if (fits_tail) begin
              mem_we     = 1'b1;
              tail_d     = tail_q + OFF_W'(siz_q.bytes);
              res_addr_d = base_q + ADDR_W'(tail_q) + ADDR_W'(4);
            end else begin
              res_status_d = ST_SYSTEM;
            end
          end
          CMD_FREE, CMD_REALLOC: begin
            // Reject outside addresses, ignore misaligned or too low ones, else walk
            if (off_q >= ADDR_W'(eff_size)) begin
              res_status_d = ST_SYSTEM;
            end else if (off_q < ADDR_W'(4) || off_q[1:0] != 2'b00) begin
              res_status_d = ST_DONE;
            end else begin
              chunk_d    = off_q[OFF_W-1:0] - OFF_W'(4);
              walk_d     = '0;
              has_prev_d = 1'b0;
              state_d    = S_WALK_RD;
            end
          end
          default: begin
            res_status_d = ST_DONE;
          end
        endcase
      end

      S_WALK_RD: begin
        // Read the next header below the tail, or give up
        if (walk_q < tail_w) begin
          mem_re  = 1'b1;
          state_d = S_WALK_CHK;
        end else begin
          state_d = S_RESP;
        end
      end

      S_WALK_CHK: begin
        if (walk_q == chunk_w) begin
          if (!mem_rdata_q[0]) begin
            state_d = S_RESP;
          end else begin
            old_d   = rsize;
            state_d = (cmd_q == CMD_FREE) ? S_REL_RD : S_REALLOC;
          end
        end else if (rsize == '0) begin
          state_d = S_RESP;
        end else begin
          // Advance to the following header, keep this one as predecessor
          has_prev_d = 1'b1;
          prev_d     = walk_q[OFF_W-1:0];
          prev_hdr_d = mem_rdata_q;
          walk_d     = walk_q + rsize;
          state_d    = S_WALK_RD;
        end
      end

      S_REALLOC: begin
        if (fits_place) begin
          // Resize in place; a tail chunk moves the tail along
          if (at_tail) begin
            mem_we    = 1'b1;
            mem_waddr = chunk_q[IDX_W+1:2];
            tail_d    = OFF_W'(chunk_w + siz_q.bytes);
          end
          res_addr_d = addr_q;
          state_d    = S_RESP;
        end else if (fits_tail) begin
          // Move to a new tail chunk, then release the old one
          mem_we       = 1'b1;
          tail_d       = tail_q + OFF_W'(siz_q.bytes);
          res_status_d = ST_MOVED;
          res_addr_d   = base_q + ADDR_W'(tail_q) + ADDR_W'(4);
          state_d      = S_REL_RD;
        end else begin
          res_status_d = ST_TO_SYSTEM;
          state_d      = S_RESP;
        end
      end

      S_REL_RD: begin
        // Read the successor header when it lies below the tail
        next_live_d = (next_off < tail_w);
        mem_re      = (next_off < tail_w);
        mem_raddr   = next_off[IDX_W+1:2];
        state_d     = S_REL_CHK;
      end

      S_REL_CHK: begin
        // Merge with a free successor and clear the used flag
        if (next_live_q && !mem_rdata_q[0]) begin
          merged_d = old_q + rsize;
        end else begin
          merged_d = old_q;
        end
        mem_we    = 1'b1;
        mem_waddr = chunk_q[IDX_W+1:2];
        mem_wdata = merged_d;
        state_d   = S_REL_PREV;
      end

      S_REL_PREV: begin
        // Merge into a free predecessor, then pull the tail back
        if (has_prev_q && !prev_hdr_q[0]) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q[IDX_W+1:2];
          mem_wdata = span;
        end
        if ((start_w + span) == tail_w) begin
          tail_d = tail_q - OFF_W'(span);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        // Hand the response to the output register once it is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    chunk_q      <= chunk_d;
    walk_q       <= walk_d;
    has_prev_q   <= has_prev_d;
    prev_q       <= prev_d;
    prev_hdr_q   <= prev_hdr_d;
    old_q        <= old_d;
    next_live_q  <= next_live_d;
    merged_q     <= merged_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_address = out_addr_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the tail buffer chunk allocator. A table of
// directed requests covers reset state, size extremes, addresses outside the
// buffer, bad addresses, double free, coalescing and every reallocate path.
// Randomized allocate/free/reallocate traffic follows over several buffer
// settings. A behavioral copy of the header store predicts each response.
// ----------------------------------------------------------------------------
module tb;
  import tbca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned IDLE_LIGHT  = 29;
  localparam int unsigned IDLE_HEAVY  = 76;
  localparam int unsigned NUM_DIR     = 24;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct packed {
    status_e           st;
    logic [ADDR_W-1:0] ra;
  } grant_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ADDR_W-1:0]   addr;
    logic [NBYTES_W-1:0] nbytes;
    logic                known;  // response typed in below, else predicted
    status_e             st;
    logic [ADDR_W-1:0]   ra;
  } dir_row_t;

  // Directed requests at reset configuration (base 0, 4096 bytes)
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{CMD_ALLOC,   32'h0000_0000, 32'd0,         1'b1, ST_DONE,   32'd4},
    '{CMD_ALLOC,   32'hffff_ffff, 32'd1,         1'b1, ST_DONE,   32'd8},
    '{CMD_ALLOC,   32'h0000_0000, 32'hffff_ffff, 1'b1, ST_SYSTEM, 32'd0},
    '{CMD_ALLOC,   32'h0000_0000, 32'd4096,      1'b1, ST_SYSTEM, 32'd0},
    '{CMD_FREE,    32'h0000_2000, 32'd0,         1'b1, ST_SYSTEM, 32'd0},
    '{CMD_FREE,    32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_SYSTEM, 32'd0},
    '{CMD_FREE,    32'h0000_0000, 32'd0,         1'b1, ST_DONE,   32'd0},
    '{CMD_FREE,    32'h0000_0006, 32'd0,         1'b1, ST_DONE,   32'd0},
    '{CMD_FREE,    32'h0000_000c, 32'd0,         1'b0, ST_DONE,   32'd0},
    '{CMD_UNUSED,  32'hffff_ffff, 32'hffff_ffff, 1'b1, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_0008, 32'd1,         1'b0, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_0008, 32'd100,       1'b0, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_0004, 32'd8,         1'b0, ST_DONE,   32'd0},
    '{CMD_FREE,    32'h0000_0008, 32'd0,         1'b0, ST_DONE,   32'd0},
    '{CMD_FREE,    32'h0000_0008, 32'd0,         1'b0, ST_DONE,   32'd0},
    '{CMD_FREE,    32'h0000_0074, 32'd0,         1'b0, ST_DONE,   32'd0},
    '{CMD_ALLOC,   32'h0000_0000, 32'd4088,      1'b0, ST_DONE,   32'd0},
    '{CMD_ALLOC,   32'h0000_0000, 32'd4,         1'b0, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_0004, 32'd4096,      1'b0, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_0004, 32'd4088,      1'b0, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'h0000_1000, 32'd0,         1'b1, ST_SYSTEM, 32'd0},
    '{CMD_REALLOC, 32'h0000_0002, 32'd5,         1'b1, ST_DONE,   32'd0},
    '{CMD_REALLOC, 32'hffff_fffc, 32'd16,        1'b1, ST_SYSTEM, 32'd0},
    '{CMD_FREE,    32'h0000_0004, 32'd0,         1'b0, ST_DONE,   32'd0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  tbca_req_if req_if ();
  tbca_rsp_if rsp_if ();

  tail_buffer_chunk_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Predicted copy of the allocator state and configuration
  logic [HDR_W-1:0]  hdr_mem [DEPTH];
  logic [OFF_W-1:0]  tail_off;
  logic [ADDR_W-1:0] cfg_base;
  logic [BUF_W-1:0]  cfg_buf;

  grant_t            owed_grants [$];
  logic [ADDR_W-1:0] live_pay [$];   // payload offsets of chunks held by the client
  grant_t            got_head;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       snd_idle_pct = 0;
  int unsigned       rcv_idle_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [33:0] eff_bytes();
    return (cfg_buf < BUF_W'(STORE_BYTES)) ? 34'(cfg_buf) : 34'(STORE_BYTES);
  endfunction

  // Header plus payload rounded up to the alignment
  function automatic logic [33:0] chunk_need(logic [NBYTES_W-1:0] n);
    logic [33:0] r;
    r = (34'(n) + 34'(ALIGN_BYTES - 1)) & ~34'(ALIGN_BYTES - 1);
    r = (r + 34'd3) & ~34'd3;
    return r + 34'd4;
  endfunction

  function automatic logic [HDR_W-1:0] hdr_bytes(logic [SIZ_W-1:0] o);
    return hdr_mem[o[IDX_W+1:2]] & ~USED_FLAG;
  endfunction

  function automatic logic hdr_used(logic [SIZ_W-1:0] o);
    return hdr_mem[o[IDX_W+1:2]][0];
  endfunction

  // Walk headers from the base; report whether c starts a chunk and its predecessor
  task automatic find_chunk(input logic [SIZ_W-1:0] c, output bit found, output bit hp,
                            output logic [SIZ_W-1:0] pv);
    logic [SIZ_W-1:0] p, s;
    bit walking;
    p = '0;
    hp = 1'b0;
    pv = '0;
    found = 1'b0;
    walking = 1'b1;
    while (walking && p < SIZ_W'(tail_off) && (p >> 2) < DEPTH) begin
      s = SIZ_W'(hdr_bytes(p));
      if (p == c) begin
        found = 1'b1;
        walking = 1'b0;
      end else if (s == '0) begin
        walking = 1'b0;
      end else begin
        hp = 1'b1;
        pv = p;
        p = p + s;
      end
    end
  endtask

  // Clear the used flag, merge with free neighbors, pull the tail back
  task automatic release_chunk(input logic [SIZ_W-1:0] c_in, input bit hp,
                               input logic [SIZ_W-1:0] pv);
    logic [SIZ_W-1:0] c, s, nx, lim;
    c = c_in;
    lim = SIZ_W'(tail_off);
    s = SIZ_W'(hdr_bytes(c));
    nx = c + s;
    if (nx < lim && !hdr_used(nx)) s = s + SIZ_W'(hdr_bytes(nx));
    hdr_mem[c[IDX_W+1:2]] = HDR_W'(s);
    if (hp && !hdr_used(pv)) begin
      s = s + SIZ_W'(hdr_bytes(pv));
      c = pv;
      hdr_mem[c[IDX_W+1:2]] = HDR_W'(s);
    end
    if (c + s == lim) tail_off = OFF_W'(lim - s);
  endtask

  // Append a used chunk at the tail if it fits
  task automatic append_chunk(input logic [33:0] need, output bit ok,
                              output logic [SIZ_W-1:0] at);
    at = SIZ_W'(tail_off);
    ok = 1'b0;
    if (34'(tail_off) + need <= eff_bytes()) begin
      hdr_mem[tail_off[IDX_W+1:2]] = HDR_W'(need) | USED_FLAG;
      tail_off = OFF_W'(34'(tail_off) + need);
      ok = 1'b1;
    end
  endtask

  // Apply one request to the header copy and work out its response
  task automatic apply_chunk_op(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input logic [NBYTES_W-1:0] nbytes,
                                output status_e st, output logic [ADDR_W-1:0] ra);
    logic [33:0]       need, old, eff, tl;
    logic [ADDR_W-1:0] off;
    logic [SIZ_W-1:0]  c, at, pv;
    bit                found, hp, ok;
    need = chunk_need(nbytes);
    eff = eff_bytes();
    st = ST_DONE;
    ra = '0;
    case (cmd) inside
      CMD_ALLOC: begin
        append_chunk(need, ok, at);
        if (ok) ra = cfg_base + 32'(at) + 32'd4;
        else st = ST_SYSTEM;
      end
      CMD_FREE, CMD_REALLOC: begin
        off = addr - cfg_base;
        if (34'(off) >= eff) begin
          st = ST_SYSTEM;
        end else if (off >= 32'd4 && off[1:0] == 2'b00) begin
          c = SIZ_W'(off - 32'd4);
          find_chunk(c, found, hp, pv);
          if (found && hdr_used(c)) begin
            if (cmd == CMD_FREE) begin
              release_chunk(c, hp, pv);
            end else begin
              old = 34'(hdr_bytes(c));
              tl = 34'(tail_off);
              if (old >= need) begin
                // shrink; only the tail chunk gives bytes back
                if (34'(c) + old == tl) begin
                  hdr_mem[c[IDX_W+1:2]] = HDR_W'(need) | USED_FLAG;
                  tail_off = OFF_W'(tl - (old - need));
                end
                ra = addr;
              end else if (34'(c) + old == tl && tl + (need - old) <= eff) begin
                hdr_mem[c[IDX_W+1:2]] = HDR_W'(need) | USED_FLAG;
                tail_off = OFF_W'(tl + need - old);
                ra = addr;
              end else begin
                append_chunk(need, ok, at);
                if (ok) begin
                  release_chunk(c, hp, pv);
                  st = ST_MOVED;
                  ra = cfg_base + 32'(at) + 32'd4;
                end else begin
                  st = ST_TO_SYSTEM;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // ----------------------------------------------------------------- drivers

  // Present one request, hold it until accepted, and record its response
  task automatic send_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [NBYTES_W-1:0] nbytes, input bit known,
                              input status_e k_st, input logic [ADDR_W-1:0] k_ra,
                              output status_e p_st, output logic [ADDR_W-1:0] p_ra);
    grant_t g;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.address       <= addr;
    req_if.request_bytes <= nbytes;
    do @(posedge clk_i); while (!req_if.ready);
    apply_chunk_op(cmd, addr, nbytes, p_st, p_ra);
    g.st = known ? k_st : p_st;
    g.ra = known ? k_ra : p_ra;
    owed_grants.push_back(g);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed response has come back
  task automatic settle_block();
    req_if.valid <= 1'b0;
    while (owed_grants.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) cfg_base = data;
    else cfg_buf = data[BUF_W-1:0];
    @(negedge clk_i);
  endtask

  // Mostly small payloads, a few large and a few that never fit
  function automatic logic [NBYTES_W-1:0] rand_bytes();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return '0;
    if (r < 72) return NBYTES_W'($urandom_range(64, 1));
    if (r < 94) return NBYTES_W'($urandom_range(700, 65));
    if (r < 97) return NBYTES_W'($urandom_range(4100, 3000));
    return $urandom;
  endfunction

  task automatic random_request();
    int unsigned       pick, idx, e;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] a, ra;
    logic [NBYTES_W-1:0] n;
    status_e           st;
    bit                live_op;
    pick = $urandom_range(99);
    live_op = 1'b0;
    idx = 0;
    n = rand_bytes();
    a = $urandom;
    e = 32'(eff_bytes());
    if (pick < 35 || (pick < 80 && live_pay.size() == 0)) begin
      cmd = CMD_ALLOC;
    end else if (pick < 80) begin
      // free or resize a chunk the client holds
      idx = $urandom_range(live_pay.size() - 1);
      a = cfg_base + live_pay[idx];
      cmd = (pick < 62) ? CMD_FREE : CMD_REALLOC;
      live_op = 1'b1;
    end else if (pick < 97) begin
      // bad or foreign addresses
      cmd = (pick < 89) ? CMD_FREE : CMD_REALLOC;
      case ($urandom_range(2))
        0: a = cfg_base + 32'($urandom_range(e / 4 + 2) * 4);
        1: a = cfg_base + 32'($urandom_range(e + 8));
        default: a = $urandom;
      endcase
    end else begin
      cmd = CMD_UNUSED;
      n = $urandom;
    end
    send_request(cmd, a, n, 1'b0, ST_DONE, '0, st, ra);
    // track what the client now holds
    if (cmd == CMD_ALLOC && st == ST_DONE) live_pay.push_back(ra - cfg_base);
    if (live_op) begin
      if (cmd == CMD_FREE && st == ST_DONE) live_pay.delete(idx);
      else if (cmd == CMD_REALLOC && (st == ST_DONE || st == ST_MOVED))
        live_pay[idx] = ra - cfg_base;
    end
  endtask

  task automatic run_segment(input logic [ADDR_W-1:0] base, input logic [BUF_W-1:0] bsz,
                             input int unsigned count, input int unsigned snd,
                             input int unsigned rcv);
    settle_block();
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    write_config(CFG_BASE_ADDRESS, base);
    write_config(CFG_BUFFER_BYTES, CFG_W'(bsz));
    repeat (count) begin
      random_request();
      if ($urandom_range(199) == 0) settle_block();
    end
  endtask

  // ------------------------------------------------------------------ checks

  // Stall the response side at random
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare each accepted response with the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_grants.size() == 0) begin
        $display("%0t: response with none owed: status %0d address %h", $time,
                 rsp_if.status, rsp_if.result_address);
        mismatches++;
      end else begin
        got_head = owed_grants.pop_front();
        if (rsp_if.status !== got_head.st) begin
          $display("%0t: status expected %0d actual %0d", $time, got_head.st,
                   rsp_if.status);
          mismatches++;
        end
        if (rsp_if.result_address !== got_head.ra) begin
          $display("%0t: result_address expected %h actual %h", $time, got_head.ra,
                   rsp_if.result_address);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    status_e           d_st;
    logic [ADDR_W-1:0] d_ra;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_BASE_ADDRESS;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.command       = CMD_ALLOC;
    req_if.address       = '0;
    req_if.request_bytes = '0;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
    tail_off = '0;
    cfg_base = BASE_RESET;
    cfg_buf  = BUF_RESET;
    snd_idle_pct = IDLE_LIGHT;
    rcv_idle_pct = IDLE_HEAVY;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table at reset configuration
    for (int i = 0; i < NUM_DIR; i++) begin
      send_request(DIR_TAB[i].cmd, DIR_TAB[i].addr, DIR_TAB[i].nbytes, DIR_TAB[i].known,
                   DIR_TAB[i].st, DIR_TAB[i].ra, d_st, d_ra);
    end

    // random traffic over several buffer settings and idle mixes
    run_segment(32'h0000_0000, 13'd4096, 200, IDLE_LIGHT, IDLE_HEAVY);
    run_segment(32'hffff_ff00, 13'd8191, 200, IDLE_LIGHT, IDLE_HEAVY);
    run_segment($urandom,      13'd256,  150, IDLE_HEAVY, IDLE_LIGHT);
    run_segment($urandom,      13'd0,    20,  IDLE_HEAVY, IDLE_LIGHT);
    run_segment($urandom,      13'd1000, 200, IDLE_HEAVY, IDLE_LIGHT);
    run_segment($urandom,      13'd4096, 230, 0, 0);
    run_segment(32'hffff_ffff, 13'd64,   100, 0, 0);
    run_segment(32'h0000_0000, 13'd4096, 100, 0, 0);

    settle_block();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tbca_pkg.sv
src/tbca_req_if.sv
src/tbca_rsp_if.sv
src/tbca_chunk_size.sv
src/tail_buffer_chunk_allocator.sv
tb/tb.sv
